// ===== rtl/tpf_pkg.sv =====
// Package with the constants, register codes and shared types of the tiled pattern fill.
`timescale 1ns / 1ps
`default_nettype none
package tpf_pkg;

  localparam int CANVAS_WIDTH  = 800;
  localparam int CANVAS_HEIGHT = 480;
  localparam int PATTERN_COLS  = 4;
  localparam int PATTERN_ROWS  = 2;

  localparam int ADDR_W  = 19;
  localparam int COORD_W = 11;
  localparam int TILE_W  = 10;
  localparam int IDX_W   = 3;
  localparam int COLOR_W = 8;
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_AREA_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_TILE_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TILE_HEIGHT = 3'd5;
  localparam logic [IDX_W-1:0] REG_COLOR_TABLE = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] area_width;
    logic [COORD_W-1:0] area_height;
    logic [TILE_W-1:0]  tile_width;
    logic [TILE_W-1:0]  tile_height;
    logic [63:0]        color_table;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pix_t;

endpackage
`default_nettype wire

// ===== rtl/tiled_pattern_fill.sv =====
// Top level of the tiled pattern fill engine.
//
// Each input transaction on the s_ channel is a tick: s_tdata bit 0 set restarts the
// fill at its first pixel, clear advances it by one pixel. A tick gives at most one
// pixel write on the m_ channel, with the canvas address and colour in m_tdata and
// m_tlast marking the final pixel of the fill. Ticks while no fill runs, or when the
// clipped area is empty, give no write.
// The result of an accepted tick appears in the output register in the next cycle.
// One tick is accepted in every cycle while the output register is empty or is being
// emptied in the same cycle, so a fill streams at one pixel per clock.
// When the receiver stalls, the held write stays in the output register and s_tready
// falls until it is taken; nothing is lost or repeated.
// Reset clears the fill state and the output register and loads the register defaults
// (tile sizes 100, all else zero). Registers sit at byte address 8*i; the user must
// write them via the APB-style port only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module tiled_pattern_fill (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [0] start_req, [7:1] zero
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [31:0]                 m_tdata,  // [18:0] pixel_address,
                                                     // [26:19] pixel_color, [31:27] zero
  output logic                             m_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tpf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tpf_pkg::PDATA_W-1:0] pwdata,
  output logic      [tpf_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import tpf_pkg::*;

  cfg_t cfg;
  pix_t res, held;
  logic step, res_valid, can_take;

  assign s_tready = can_take;
  assign step     = s_tvalid & s_tready;

  tpf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpf_fill u_fill (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .start_req (s_tdata[0]),
    .res_valid (res_valid),
    .res       (res)
  );

  tpf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .pix_in    (res),
    .can_take  (can_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pix_out   (held)
  );

  assign m_tdata = {5'b0, held.pixel_color, held.pixel_address};
  assign m_tlast = held.last_pixel;

endmodule
`default_nettype wire

// ===== rtl/tpf_regs.sv =====
// Configuration register bank with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none
module tpf_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tpf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tpf_pkg::PDATA_W-1:0] pwdata,
  output logic      [tpf_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output tpf_pkg::cfg_t                    cfg
);
  import tpf_pkg::*;

  logic [IDX_W-1:0] reg_index;
  logic             wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_W-1:3];
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.area_width  <= '0;
      cfg.area_height <= '0;
      cfg.tile_width  <= TILE_W'(100);
      cfg.tile_height <= TILE_W'(100);
      cfg.color_table <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_ORIGIN_X:    cfg.origin_x    <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:    cfg.origin_y    <= pwdata[COORD_W-1:0];
        REG_AREA_WIDTH:  cfg.area_width  <= pwdata[COORD_W-1:0];
        REG_AREA_HEIGHT: cfg.area_height <= pwdata[COORD_W-1:0];
        REG_TILE_WIDTH:  cfg.tile_width  <= pwdata[TILE_W-1:0];
        REG_TILE_HEIGHT: cfg.tile_height <= pwdata[TILE_W-1:0];
        REG_COLOR_TABLE: cfg.color_table <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ORIGIN_X:    prdata = PDATA_W'(cfg.origin_x);
      REG_ORIGIN_Y:    prdata = PDATA_W'(cfg.origin_y);
      REG_AREA_WIDTH:  prdata = PDATA_W'(cfg.area_width);
      REG_AREA_HEIGHT: prdata = PDATA_W'(cfg.area_height);
      REG_TILE_WIDTH:  prdata = PDATA_W'(cfg.tile_width);
      REG_TILE_HEIGHT: prdata = PDATA_W'(cfg.tile_height);
      REG_COLOR_TABLE: prdata = cfg.color_table;
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tpf_fill.sv =====
// Fill position counters and the per-pixel address and colour logic.
`timescale 1ns / 1ps
`default_nettype none
module tpf_fill (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tpf_pkg::cfg_t cfg,
  input  wire logic          step,
  input  wire logic          start_req,
  output logic               res_valid,
  output tpf_pkg::pix_t      res
);
  import tpf_pkg::*;

  logic [COORD_W-1:0] offset_x, offset_y;
  logic [TILE_W-1:0]  block_pixel_x, block_pixel_y;
  logic [IDX_W-1:0]   column_index, row_index;
  logic [ADDR_W-1:0]  row_base_address;
  logic               fill_active;

  logic [COORD_W-1:0] offset_x_next, offset_y_next;
  logic [TILE_W-1:0]  block_pixel_x_next, block_pixel_y_next;
  logic [IDX_W-1:0]   column_index_next, row_index_next;
  logic [ADDR_W-1:0]  row_base_address_next;
  logic               fill_active_next;

  logic               start;
  logic               active;
  logic [21:0]        start_base;
  logic [COORD_W-1:0] avail_x, avail_y, eff_w, eff_h;
  logic [COORD_W-1:0] cur_ox, cur_oy;
  logic [TILE_W-1:0]  cur_bx, cur_by, bx_inc, by_inc, tw, th;
  logic [IDX_W-1:0]   cur_col, cur_row;
  logic [ADDR_W-1:0]  cur_base;
  logic [COORD_W:0]   ox_inc, oy_inc;
  logic [IDX_W:0]     col_inc, row_inc;
  logic [5:0]         lane_sum;
  logic [IDX_W-1:0]   lane;
  logic               in_bounds, produce, last;

  assign start      = step & start_req;
  assign active     = start | fill_active;
  assign start_base = 22'(cfg.origin_y) * 22'(CANVAS_WIDTH) + 22'(cfg.origin_x);

  assign avail_x = (cfg.origin_x < COORD_W'(CANVAS_WIDTH))
                   ? COORD_W'(CANVAS_WIDTH) - cfg.origin_x : '0;
  assign avail_y = (cfg.origin_y < COORD_W'(CANVAS_HEIGHT))
                   ? COORD_W'(CANVAS_HEIGHT) - cfg.origin_y : '0;
  assign eff_w   = (cfg.area_width < avail_x) ? cfg.area_width : avail_x;
  assign eff_h   = (cfg.area_height < avail_y) ? cfg.area_height : avail_y;
  assign tw      = (cfg.tile_width == '0) ? TILE_W'(1) : cfg.tile_width;
  assign th      = (cfg.tile_height == '0) ? TILE_W'(1) : cfg.tile_height;

  assign cur_ox   = start ? '0 : offset_x;
  assign cur_oy   = start ? '0 : offset_y;
  assign cur_bx   = start ? '0 : block_pixel_x;
  assign cur_by   = start ? '0 : block_pixel_y;
  assign cur_col  = start ? '0 : column_index;
  assign cur_row  = start ? '0 : row_index;
  assign cur_base = start ? start_base[ADDR_W-1:0] : row_base_address;

  assign ox_inc  = {1'b0, cur_ox} + 1'b1;
  assign oy_inc  = {1'b0, cur_oy} + 1'b1;
  assign bx_inc  = cur_bx + 1'b1;
  assign by_inc  = cur_by + 1'b1;
  assign col_inc = {1'b0, cur_col} + 1'b1;
  assign row_inc = {1'b0, cur_row} + 1'b1;

  assign in_bounds = (cur_ox < eff_w) && (cur_oy < eff_h);
  assign produce   = step & active & in_bounds;
  assign last      = (ox_inc >= {1'b0, eff_w}) && (oy_inc >= {1'b0, eff_h});

  assign lane_sum = 6'(cur_row) * 6'(PATTERN_COLS) + 6'(cur_col);
  assign lane     = lane_sum[IDX_W-1:0];

  assign res_valid         = produce;
  assign res.pixel_address = cur_base + ADDR_W'(cur_ox);
  assign res.pixel_color   = cfg.color_table[{lane, 3'b000} +: COLOR_W];
  assign res.last_pixel    = last;

  always_comb begin
    offset_x_next         = cur_ox;
    offset_y_next         = cur_oy;
    block_pixel_x_next    = cur_bx;
    block_pixel_y_next    = cur_by;
    column_index_next     = cur_col;
    row_index_next        = cur_row;
    row_base_address_next = cur_base;
    fill_active_next      = produce & ~last;
    if (produce) begin
      if (ox_inc < {1'b0, eff_w}) begin
        offset_x_next = ox_inc[COORD_W-1:0];
        if (bx_inc >= tw) begin
          block_pixel_x_next = '0;
          column_index_next  = (col_inc >= (IDX_W+1)'(PATTERN_COLS)) ? '0
                               : col_inc[IDX_W-1:0];
        end else begin
          block_pixel_x_next = bx_inc;
        end
      end else begin
        offset_x_next         = '0;
        block_pixel_x_next    = '0;
        column_index_next     = '0;
        offset_y_next         = oy_inc[COORD_W-1:0];
        row_base_address_next = cur_base + ADDR_W'(CANVAS_WIDTH);
        if (by_inc >= th) begin
          block_pixel_y_next = '0;
          row_index_next     = (row_inc >= (IDX_W+1)'(PATTERN_ROWS)) ? '0
                               : row_inc[IDX_W-1:0];
        end else begin
          block_pixel_y_next = by_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x         <= '0;
      offset_y         <= '0;
      block_pixel_x    <= '0;
      block_pixel_y    <= '0;
      column_index     <= '0;
      row_index        <= '0;
      row_base_address <= '0;
      fill_active      <= 1'b0;
    end else if (step && active) begin
      offset_x         <= offset_x_next;
      offset_y         <= offset_y_next;
      block_pixel_x    <= block_pixel_x_next;
      block_pixel_y    <= block_pixel_y_next;
      column_index     <= column_index_next;
      row_index        <= row_index_next;
      row_base_address <= row_base_address_next;
      fill_active      <= fill_active_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpf_out.sv =====
// Output register that holds one pixel write until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module tpf_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire tpf_pkg::pix_t pix_in,
  output logic               can_take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tpf_pkg::pix_t      pix_out
);
  import tpf_pkg::*;

  assign can_take = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_out <= pix_in;
    end
  end

endmodule
`default_nettype wire
